[design/emvt_pkg.sv]
package emvt_pkg;
    localparam int EDGE_DEPTH   = 4096;
    localparam int VERTEX_DEPTH = 4096;
    localparam int COORD_BITS   = 24;
    localparam int EW = $clog2(EDGE_DEPTH);
    localparam int VW = $clog2(VERTEX_DEPTH);
    localparam int TOL_W = 16;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_DUP     = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_ESCAN, S_EWAIT, S_VREAD, S_VWAIT, S_VCHK,
        S_LSCAN, S_LWAIT, S_DECIDE, S_WRB, S_OUT
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;
endpackage

[design/emvt_if.sv]
interface emvt_in_if import emvt_pkg::*; ();
    logic valid;
    logic ready;
    logic [11:0] src_vertex_a;
    logic [11:0] src_vertex_b;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic last_of_block;
    modport source (output valid, src_vertex_a, src_vertex_b, ax, ay, az, bx, by_coord, bz,
                    last_of_block, input ready);
    modport sink (input valid, src_vertex_a, src_vertex_b, ax, ay, az, bx, by_coord, bz,
                  last_of_block, output ready);
endinterface

interface emvt_out_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [11:0] edge_index;
    logic [11:0] out_vertex_a;
    logic [11:0] out_vertex_b;
    logic [12:0] vertex_total;
    modport source (output valid, status, edge_index, out_vertex_a, out_vertex_b,
                    vertex_total, input ready);
    modport sink (input valid, status, edge_index, out_vertex_a, out_vertex_b,
                  vertex_total, output ready);
endinterface

[design/edge_merge_with_vertex_tolerance.sv]
// Edge merge with vertex tolerance.
// Input channel (emvt_in_if): one word per edge, two block-local vertex ids,
// both endpoint coordinates and a last-of-block flag.
// Output channel (emvt_out_if): one word per input edge with status, edge
// index, merged vertex ids and the committed vertex count.
// APB port: register 0 at address 0 is match_tolerance (reset 13).
// Sequence: each edge scans the edges stored before the current block; for each
// one, one edge memory read, then four vertex memory reads through one shared
// compare unit; the block vertex list memory is then scanned entry by entry.
// A duplicate skips the list scan. One edge is worked on at a time; ready is
// low meanwhile.
// The result is held in an output register until taken; a stalled receiver
// holds the block, and the next edge is taken when the result leaves.
// Reset is synchronous active low and clears counters and the sequencer;
// memory contents are not cleared, none is read before written.
module edge_merge_with_vertex_tolerance import emvt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    emvt_in_if.sink       i_in,
    emvt_out_if.source    o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    localparam int CW = EW + 1;
    localparam int NW = VW + 1;

    t_state r_st, n_st;
    logic [TOL_W-1:0] r_tol;
    logic [CW-1:0] r_ecnt, r_base, r_e;
    logic [NW-1:0] r_comm, r_lcnt, r_li;
    logic [11:0] r_sa, r_sb;
    t_point r_pa, r_pb;
    logic r_last;
    logic [VW-1:0] r_v0, r_v1, r_ida, r_idb;
    logic r_mapa, r_mapb, r_dup, r_h00, r_h01, r_h10;
    logic r_fa, r_fb;
    logic [NW-1:0] r_posa, r_posb;
    logic [1:0] r_ph;
    logic [1:0] r_status;
    logic [11:0] r_oeidx, r_oa, r_ob;

    // memories
    logic e_we;
    logic [EW-1:0] e_addr_w, e_addr_r;
    logic [2*VW-1:0] e_wd, e_rd;
    logic v_we;
    logic [VW-1:0] v_aw, v_ar;
    t_point v_wd, v_rd;
    logic l_we;
    logic [VW-1:0] l_aw, l_ar;
    logic [11:0] l_wd, l_rd;

    emvt_ram #(.WIDTH(2*VW), .DEPTH(EDGE_DEPTH)) u_eram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_addr_w), .i_wdata(e_wd),
        .i_raddr(e_addr_r), .o_rdata(e_rd));
    emvt_ram #(.WIDTH(3*COORD_BITS), .DEPTH(VERTEX_DEPTH)) u_vram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_aw), .i_wdata(v_wd),
        .i_raddr(v_ar), .o_rdata(v_rd));
    emvt_ram #(.WIDTH(12), .DEPTH(VERTEX_DEPTH)) u_lram (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_aw), .i_wdata(l_wd),
        .i_raddr(l_ar), .o_rdata(l_rd));

    // shared compare unit: point vs vertex memory data
    logic hit;
    emvt_near u_near (.i_p(r_ph[1] ? r_pb : r_pa), .i_q(v_rd), .i_tol(r_tol), .o_hit(hit));

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, r_tol} : 32'd0;

    logic [NW-1:0] ida_c, idb_c, n_c;
    logic ok_c, adda_c, addb_c;
    logic [NW-1:0] pa_c, pb_c;

    always_comb begin
        pa_c = r_fa ? r_posa : r_lcnt;
        adda_c = !r_mapa && !r_fa;
        n_c = r_lcnt + NW'(adda_c);
        if (adda_c && r_sb == r_sa) begin
            pb_c = pa_c; addb_c = 1'b0;
        end else if (r_fb) begin
            pb_c = r_posb; addb_c = 1'b0;
        end else begin
            pb_c = n_c; addb_c = !r_mapb;
        end
        ida_c = r_mapa ? NW'(r_ida) : r_comm + pa_c;
        idb_c = r_mapb ? NW'(r_idb) : r_comm + pb_c;
        ok_c = (r_ecnt < CW'(EDGE_DEPTH))
            && (r_mapa || ida_c < NW'(VERTEX_DEPTH))
            && (r_mapb || idb_c < NW'(VERTEX_DEPTH));
    end

    always_comb begin
        n_st = r_st;
        e_we = 1'b0; e_addr_w = r_ecnt[EW-1:0]; e_wd = {r_ida, r_idb};
        e_addr_r = r_e[EW-1:0];
        v_we = 1'b0; v_aw = r_ida; v_wd = r_pa;
        v_ar = r_ph[0] ? r_v1 : r_v0;
        l_we = 1'b0; l_aw = pa_c[VW-1:0]; l_wd = r_sa;
        l_ar = r_li[VW-1:0];
        i_in.ready = (r_st == S_IDLE);
        o_out.valid = (r_st == S_OUT);
        unique case (r_st)
            S_IDLE:   if (i_in.valid) n_st = S_ESCAN;
            S_ESCAN:  n_st = (r_e < r_base) ? S_EWAIT : S_LSCAN;
            S_EWAIT:  n_st = S_VREAD;
            S_VREAD:  n_st = S_VWAIT;
            S_VWAIT:  n_st = S_VCHK;
            S_VCHK:   n_st = (r_ph == 2'd3) ? S_ESCAN : S_VREAD;
            S_LSCAN:  n_st = r_dup ? S_OUT : ((r_li < r_lcnt) ? S_LWAIT : S_DECIDE);
            S_LWAIT:  n_st = S_LSCAN;
            S_DECIDE: begin
                n_st = S_OUT;
                if (ok_c) begin
                    n_st = S_WRB;
                    e_we = 1'b1;
                    e_wd = {ida_c[VW-1:0], idb_c[VW-1:0]};
                    v_we = 1'b1; v_aw = ida_c[VW-1:0];
                    l_we = adda_c; l_aw = pa_c[VW-1:0]; l_wd = r_sa;
                end
            end
            S_WRB: begin
                n_st = S_OUT;
                v_we = 1'b1; v_aw = r_idb; v_wd = r_pb;
                l_we = r_fa; l_aw = r_posb[VW-1:0]; l_wd = r_sb;
            end
            S_OUT:    if (o_out.ready) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    assign o_out.status = r_status;
    assign o_out.edge_index = r_oeidx;
    assign o_out.out_vertex_a = r_oa;
    assign o_out.out_vertex_b = r_ob;
    assign o_out.vertex_total = 13'(r_comm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_tol <= TOL_W'(13);
            r_ecnt <= '0; r_base <= '0; r_comm <= '0; r_lcnt <= '0;
        end else begin
            r_st <= n_st;
            if (psel && penable && pwrite && paddr == 2'd0) r_tol <= pwdata[TOL_W-1:0];
            unique case (r_st)
                S_IDLE: if (i_in.valid) begin
                    r_sa <= i_in.src_vertex_a; r_sb <= i_in.src_vertex_b;
                    r_pa <= '{i_in.ax, i_in.ay, i_in.az};
                    r_pb <= '{i_in.bx, i_in.by_coord, i_in.bz};
                    r_last <= i_in.last_of_block;
                    r_e <= '0; r_li <= '0; r_ph <= '0;
                    r_mapa <= 1'b0; r_mapb <= 1'b0; r_dup <= 1'b0;
                    r_ida <= '0; r_idb <= '0; r_fa <= 1'b0; r_fb <= 1'b0;
                    r_posa <= '0; r_posb <= '0;
                end
                S_ESCAN: begin
                    r_h00 <= 1'b0; r_h01 <= 1'b0; r_h10 <= 1'b0;
                    r_ph <= '0;
                end
                S_EWAIT: begin
                    r_v0 <= e_rd[2*VW-1:VW]; r_v1 <= e_rd[VW-1:0];
                end
                S_VCHK: begin
                    // phases: 0 pa/v0, 1 pa/v1, 2 pb/v0, 3 pb/v1
                    unique case (r_ph)
                        2'd0: if (hit) begin r_h00 <= 1'b1; r_mapa <= 1'b1; r_ida <= r_v0; end
                        2'd1: if (hit && !r_h00) begin
                            r_h01 <= 1'b1; r_mapa <= 1'b1; r_ida <= r_v1;
                        end
                        2'd2: if (hit) begin r_h10 <= 1'b1; r_mapb <= 1'b1; r_idb <= r_v0; end
                        2'd3: begin
                            if (hit && !r_h10) begin r_mapb <= 1'b1; r_idb <= r_v1; end
                            if ((r_h00 && hit && !r_h10) || (r_h01 && r_h10)) r_dup <= 1'b1;
                            r_e <= r_e + CW'(1);
                        end
                        default: ;
                    endcase
                    r_ph <= r_ph + 2'd1;
                end
                S_LWAIT: begin
                    if (!r_fa && l_rd == r_sa) begin r_fa <= 1'b1; r_posa <= r_li; end
                    if (!r_fb && l_rd == r_sb) begin r_fb <= 1'b1; r_posb <= r_li; end
                    r_li <= r_li + NW'(1);
                end
                S_DECIDE: begin
                    r_ida <= ida_c[VW-1:0]; r_idb <= idb_c[VW-1:0];
                    r_fa <= addb_c; r_posb <= pb_c;
                    if (ok_c) begin
                        r_status <= ST_ADDED;
                        r_oeidx <= 12'(r_ecnt); r_oa <= 12'(ida_c); r_ob <= 12'(idb_c);
                        r_ecnt <= r_ecnt + CW'(1);
                        r_lcnt <= n_c + NW'(addb_c);
                    end else begin
                        r_status <= ST_REFUSED;
                        r_oeidx <= '0; r_oa <= '0; r_ob <= '0;
                        if (r_last) begin
                            r_comm <= r_comm + r_lcnt; r_lcnt <= '0; r_base <= r_ecnt;
                        end
                    end
                end
                S_WRB: if (r_last) begin
                    r_comm <= r_comm + r_lcnt; r_lcnt <= '0; r_base <= r_ecnt;
                end
                S_LSCAN: if (r_dup) begin
                    r_status <= ST_DUP;
                    r_oeidx <= '0; r_oa <= '0; r_ob <= '0;
                    if (r_last) begin
                        r_comm <= r_comm + r_lcnt; r_lcnt <= '0; r_base <= r_ecnt;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[design/emvt_ram.sv]
module emvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/emvt_near.sv]
module emvt_near import emvt_pkg::*; (
    input  t_point           i_p,
    input  t_point           i_q,
    input  logic [TOL_W-1:0] i_tol,
    output logic             o_hit
);
    logic signed [COORD_BITS:0] dx, dy, dz;
    logic [COORD_BITS:0] mx, my, mz;

    always_comb begin
        dx = {i_p.x[COORD_BITS-1], i_p.x} - {i_q.x[COORD_BITS-1], i_q.x};
        dy = {i_p.y[COORD_BITS-1], i_p.y} - {i_q.y[COORD_BITS-1], i_q.y};
        dz = {i_p.z[COORD_BITS-1], i_p.z} - {i_q.z[COORD_BITS-1], i_q.z};
        mx = dx[COORD_BITS] ? -dx : dx;
        my = dy[COORD_BITS] ? -dy : dy;
        mz = dz[COORD_BITS] ? -dz : dz;
        o_hit = (mx < (COORD_BITS+1)'(i_tol)) && (my < (COORD_BITS+1)'(i_tol))
             && (mz < (COORD_BITS+1)'(i_tol));
    end
endmodule

[test/edge_merge_with_vertex_tolerance_tb.sv]
module edge_merge_with_vertex_tolerance_tb;
    import emvt_pkg::*;

    localparam int REG_MATCH_TOL = 0;
    localparam int IDLE_LIMIT    = 20000;
    localparam int NUM_RANDOM    = 112;

    typedef struct {
        logic [11:0]           sa;
        logic [11:0]           sb;
        logic [COORD_BITS-1:0] c[6];
        logic                  last;
    } t_seg_word;

    typedef struct {
        t_status     status;
        logic [11:0] eidx;
        logic [11:0] va;
        logic [11:0] vb;
        logic [12:0] total;
    } t_merge_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    emvt_in_if  in_if();
    emvt_out_if out_if();

    edge_merge_with_vertex_tolerance dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow graph state
    logic [COORD_BITS-1:0] vert_x[VERTEX_DEPTH];
    logic [COORD_BITS-1:0] vert_y[VERTEX_DEPTH];
    logic [COORD_BITS-1:0] vert_z[VERTEX_DEPTH];
    logic [11:0]           link_a[EDGE_DEPTH];
    logic [11:0]           link_b[EDGE_DEPTH];
    logic [11:0]           block_ids[VERTEX_DEPTH];
    int unsigned           link_count = 0;
    int unsigned           base_links = 0;
    int unsigned           committed = 0;
    int unsigned           block_len = 0;
    int unsigned           tol_q = 13;

    t_merge_result pending_results[$];
    int  mismatches = 0;
    int  hold_cycles = 0;
    bit  rx_stall = 1'b0;
    bit  tx_gaps = 1'b0;
    int  idle_count = 0;
    int  rx_phase = 0;

    function automatic bit axis_near(longint p, logic [COORD_BITS-1:0] s);
        longint d;
        d = p - longint'($signed(s));
        if (d < 0) d = -d;
        return d < longint'(tol_q);
    endfunction

    function automatic bit vert_near(longint p[3], logic [11:0] id);
        return axis_near(p[0], vert_x[id]) && axis_near(p[1], vert_y[id]) &&
               axis_near(p[2], vert_z[id]);
    endfunction

    function automatic int unsigned block_pos(logic [11:0] src);
        for (int unsigned i = 0; i < block_len; i++)
            if (block_ids[i] == src) return i;
        return block_len;
    endfunction

    function automatic t_merge_result merge_predict(t_seg_word w);
        t_merge_result r;
        longint pa[3], pb[3];
        bit dup, mapa, mapb, adda, addb, ok, h00, h01, h10, h11;
        int unsigned ida, idb, n, posa, posb;
        for (int k = 0; k < 3; k++) begin
            pa[k] = longint'($signed(w.c[k]));
            pb[k] = longint'($signed(w.c[k+3]));
        end
        dup = 0; mapa = 0; mapb = 0; ida = 0; idb = 0;
        r = '{ST_ADDED, '0, '0, '0, '0};
        for (int unsigned e = 0; e < base_links; e++) begin
            h00 = 0; h01 = 0; h10 = 0; h11 = 0;
            if (vert_near(pa, link_a[e])) begin
                h00 = 1; mapa = 1; ida = link_a[e];
            end else if (vert_near(pa, link_b[e])) begin
                h01 = 1; mapa = 1; ida = link_b[e];
            end
            if (vert_near(pb, link_a[e])) begin
                h10 = 1; mapb = 1; idb = link_a[e];
            end else if (vert_near(pb, link_b[e])) begin
                h11 = 1; mapb = 1; idb = link_b[e];
            end
            if ((h00 && h11) || (h01 && h10)) dup = 1;
        end
        if (dup) begin
            r.status = ST_DUP;
        end else begin
            n = block_len; posa = 0; posb = 0; adda = 0; addb = 0;
            ok = link_count < EDGE_DEPTH;
            if (!mapa) begin
                posa = block_pos(w.sa);
                if (posa == n) begin
                    adda = 1; n++;
                end
                ida = committed + posa;
                if (ida >= VERTEX_DEPTH) ok = 0;
            end
            if (!mapb) begin
                if (adda && w.sb == w.sa) begin
                    posb = posa;
                end else begin
                    posb = block_pos(w.sb);
                    if (posb == block_len) begin
                        posb = n; addb = 1; n++;
                    end
                end
                idb = committed + posb;
                if (idb >= VERTEX_DEPTH) ok = 0;
            end
            if (!ok) begin
                r.status = ST_REFUSED;
            end else begin
                if (adda) block_ids[posa] = w.sa;
                if (addb) block_ids[posb] = w.sb;
                block_len = n;
                r.eidx = 12'(link_count);
                link_a[link_count] = 12'(ida);
                link_b[link_count] = 12'(idb);
                link_count++;
                vert_x[ida] = w.c[0]; vert_y[ida] = w.c[1]; vert_z[ida] = w.c[2];
                vert_x[idb] = w.c[3]; vert_y[idb] = w.c[4]; vert_z[idb] = w.c[5];
                r.va = 12'(ida);
                r.vb = 12'(idb);
            end
        end
        if (w.last) begin
            committed += block_len;
            block_len = 0;
            base_links = link_count;
        end
        r.total = 13'(committed);
        return r;
    endfunction

    task automatic send_word(t_seg_word w);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid = 1'b1;
        in_if.src_vertex_a = w.sa;
        in_if.src_vertex_b = w.sb;
        in_if.ax = w.c[0]; in_if.ay = w.c[1]; in_if.az = w.c[2];
        in_if.bx = w.c[3]; in_if.by_coord = w.c[4]; in_if.bz = w.c[5];
        in_if.last_of_block = w.last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_results.push_back(merge_predict(w));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_tolerance(int unsigned v);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = 2'(REG_MATCH_TOL * 4); pwdata = 32'(v);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tol_q = v & 16'hFFFF;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    function automatic t_seg_word mk_word(logic [11:0] sa, logic [11:0] sb,
                                          int ax, int ay, int az,
                                          int bx, int by, int bz, bit last);
        t_seg_word w;
        w.sa = sa; w.sb = sb; w.last = last;
        w.c[0] = 24'(ax); w.c[1] = 24'(ay); w.c[2] = 24'(az);
        w.c[3] = 24'(bx); w.c[4] = 24'(by); w.c[5] = 24'(bz);
        return w;
    endfunction

    function automatic logic [COORD_BITS-1:0] jitter(logic [COORD_BITS-1:0] v);
        int m;
        m = (tol_q == 0) ? 0 : ((tol_q - 1 > 40) ? 40 : int'(tol_q) - 1);
        return v + 24'(int'($urandom_range(0, 2 * m)) - m);
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return (24'h800000 ^ 24'($urandom_range(0, 3)));
            default: return 24'(int'($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    // mostly near-copies of one or both endpoints of stored segments, the rest fresh
    function automatic t_seg_word rand_word();
        t_seg_word w;
        int unsigned e, kind;
        logic [11:0] v0, v1;
        w.sa = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
        w.sb = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
        w.last = ($urandom_range(0, 5) == 0);
        for (int k = 0; k < 6; k++) w.c[k] = rand_coord();
        kind = $urandom_range(0, 9);
        if (base_links != 0 && kind < 7) begin
            e = $urandom_range(0, base_links - 1);
            v0 = link_a[e]; v1 = link_b[e];
            if ($urandom_range(0, 1)) begin
                v0 = link_b[e]; v1 = link_a[e];
            end
            w.c[0] = jitter(vert_x[v0]); w.c[1] = jitter(vert_y[v0]);
            w.c[2] = jitter(vert_z[v0]);
            if (kind < 4) begin
                w.c[3] = jitter(vert_x[v1]); w.c[4] = jitter(vert_y[v1]);
                w.c[5] = jitter(vert_z[v1]);
            end else if (kind == 4) begin
                e = $urandom_range(0, base_links - 1);
                w.c[3] = jitter(vert_x[link_b[e]]); w.c[4] = jitter(vert_y[link_b[e]]);
                w.c[5] = jitter(vert_z[link_b[e]]);
            end
        end
        return w;
    endfunction

    // receiver: stall pattern plus a long hold-off on request
    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (hold_cycles > 0) begin
            out_if.ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (rx_stall) begin
            out_if.ready = (rx_phase % 11 < 7) && ($urandom_range(0, 4) != 0);
        end else begin
            out_if.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_merge_result x;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                x = pending_results.pop_front();
                if (out_if.status !== x.status) begin
                    $error("status: expected %0d actual %0d", x.status, out_if.status);
                    mismatches++;
                end
                if (out_if.edge_index !== x.eidx) begin
                    $error("edge_index: expected %0d actual %0d", x.eidx, out_if.edge_index);
                    mismatches++;
                end
                if (out_if.out_vertex_a !== x.va) begin
                    $error("out_vertex_a: expected %0d actual %0d", x.va, out_if.out_vertex_a);
                    mismatches++;
                end
                if (out_if.out_vertex_b !== x.vb) begin
                    $error("out_vertex_b: expected %0d actual %0d", x.vb, out_if.out_vertex_b);
                    mismatches++;
                end
                if (out_if.vertex_total !== x.total) begin
                    $error("vertex_total: expected %0d actual %0d", x.total,
                           out_if.vertex_total);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !i_rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        send_word(mk_word(12'd0, 12'd4095, 0, 0, 0, 8388607, 8388607, 8388607, 1'b0));
        send_word(mk_word(12'd4095, 12'd0, -8388608, -8388608, -8388608, 100, 200, 300, 1'b0));
        send_word(mk_word(12'd7, 12'd7, 1000, 1000, 1000, 1000, 1000, 1000, 1'b0));
        send_word(mk_word(12'hAAA, 12'h555, 5000, -5000, 5000, -7000, 7000, -7000, 1'b1));
        // same segment again, both directions, and with the tolerance edge
        send_word(mk_word(12'd1, 12'd2, 0, 0, 0, 8388607, 8388607, 8388607, 1'b0));
        send_word(mk_word(12'd1, 12'd2, 8388607, 8388607, 8388607, 0, 0, 0, 1'b0));
        send_word(mk_word(12'd3, 12'd4, 12, -12, 12, 8388595, 8388595, 8388595, 1'b0));
        send_word(mk_word(12'd3, 12'd4, 13, 0, 0, 8388607, 8388607, 8388607, 1'b0));
        send_word(mk_word(12'd5, 12'd6, 1000, 1000, 1000, 42, 42, 42, 1'b0));
        send_word(mk_word(12'd6, 12'd6, 77, 77, 77, 88, 88, 88, 1'b0));
        send_word(mk_word(12'd5, 12'd9, 5000, -5000, 5000, -7000, 7000, -7000, 1'b1));
        send_word(mk_word(12'd8, 12'd8, 100, 200, 300, -8388608, -8388608, -8388608, 1'b1));
        send_word(mk_word(12'd0, 12'd1, 77, 77, 77, 42, 42, 42, 1'b0));
        send_word(mk_word(12'd0, 12'd1, 3, 3, 3, 4, 4, 4, 1'b1));
        drain();
    endtask

    task automatic test_tolerance_settings();
        write_tolerance(0);
        send_word(mk_word(12'd0, 12'd1, 0, 0, 0, 8388607, 8388607, 8388607, 1'b1));
        drain();
        write_tolerance(65535);
        send_word(mk_word(12'd2, 12'd3, 30000, 30000, 30000, 8388607, 8388607, 8388607, 1'b0));
        send_word(mk_word(12'd2, 12'd3, 65535, 0, 0, 8388607, 8388607, 8388607, 1'b1));
        drain();
        write_tolerance($urandom_range(1, 300));
        for (int i = 0; i < 6; i++) send_word(rand_word());
        drain();
        write_tolerance(13);
    endtask

    task automatic test_random();
        tx_gaps = 1'b1;
        rx_stall = 1'b1;
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM / 2) begin
                drain();
                write_tolerance($urandom_range(2, 60));
            end
            if (i % 40 == 20) rx_stall = ~rx_stall;
            send_word(rand_word());
        end
        drain();
    endtask

    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_stall = 1'b0;
        hold_cycles = 400;
        for (int i = 0; i < 5; i++) send_word(rand_word());
        drain();
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.src_vertex_a = '0;
        in_if.src_vertex_b = '0;
        in_if.ax = '0; in_if.ay = '0; in_if.az = '0;
        in_if.bx = '0; in_if.by_coord = '0; in_if.bz = '0;
        in_if.last_of_block = 1'b0;
        out_if.ready = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        write_tolerance(13);
        test_directed();
        test_tolerance_settings();
        test_random();
        test_backpressure();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
